[hdl/windowed_bitmap_sorter_macros.svh]
// ----------------------------------------------------------------------------
// windowed_bitmap_sorter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef WINDOWED_BITMAP_SORTER_MACROS_SVH
`define WINDOWED_BITMAP_SORTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define WBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define WBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wbs_pkg.sv]
// ----------------------------------------------------------------------------
// wbs_pkg
// shared types and constants of the windowed bitmap sorter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbs_pkg;

    localparam int VALUE_W   = 24;
    localparam int MAX_BIT_W = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_INS_RD,
        ST_INS_WR,
        ST_POP_SCAN,
        ST_POP_WR
    } state_t;

    // lowest set bit of one bitmap word
    typedef struct packed {
        logic                 hit;
        logic [MAX_BIT_W-1:0] idx;
    } lowbit_t;

endpackage

[hdl/wbs_lowbit.sv]
// ----------------------------------------------------------------------------
// wbs_lowbit
// finds the lowest set bit of a bitmap word and gives the word with it cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbs_lowbit
#(
    parameter int WORD_BITS = 32
)
(
    input  logic [WORD_BITS-1:0] word,
    output wbs_pkg::lowbit_t     low,
    output logic [WORD_BITS-1:0] cleared
);
    import wbs_pkg::*;

    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] iso;
    logic [BW-1:0]        idx;

    // two's complement trick isolates the lowest one
    assign iso = word & (~word + {{(WORD_BITS-1){1'b0}}, 1'b1});

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            idx = idx | ({BW{iso[i]}} & BW'(i));
        end
    end

    assign low.hit = |word;
    assign low.idx = MAX_BIT_W'(idx);
    assign cleared = word & ~iso;

endmodule

[hdl/windowed_bitmap_sorter.sv]
// ----------------------------------------------------------------------------
// windowed_bitmap_sorter
// presence bitmap over one value window: insert sets a bit, pop returns the
// smallest stored value and clears its bit
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  request   start, busy, opcode, value           in (start), out (busy)
//  result    done, found, sorted_value            out
//  config    cfg_valid, cfg_ready, cfg_data       in, out (ready), in
//
//  insert: word and bit index by shift with a power-of-two WORD_BITS, else
//  by reciprocal multiply for the word index, then the bit remainder; then
//  one bitmap read-modify-write. pop: one extra read per empty word skipped,
//  the scan reads one bitmap word per cycle through the single read port.
//  out-of-window insert and pop on an empty bitmap: no bitmap access.
//  after reset the bitmap is cleared one word per cycle, ceil(WINDOW /
//  WORD_BITS) words, busy is high meanwhile; config writes are always taken.
//  results show for one cycle on done; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_bitmap_sorter
#(
    parameter int WINDOW    = 65536,
    parameter int WORD_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [wbs_pkg::VALUE_W-1:0] value,
    output logic                        done,
    output logic                        found,
    output logic [wbs_pkg::VALUE_W-1:0] sorted_value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wbs_pkg::VALUE_W-1:0] cfg_data
);
    import wbs_pkg::*;

    localparam int NWORDS  = (WINDOW + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW      = $clog2(WORD_BITS);
    localparam int RW      = BW + 1;
    localparam int OFF_W   = $clog2(WINDOW);
    localparam int CW      = $clog2(WINDOW + 1);
    localparam int IDX_W   = VALUE_W + 1;
    localparam bit WB_POW2 = ((1 << BW) == WORD_BITS);
    localparam int S_SH    = OFF_W + BW;
    localparam int RCP_W   = OFF_W + 2;
    localparam int PW      = OFF_W + RCP_W;
    // ceil(2^S_SH / WORD_BITS), exact quotient for every window offset
    localparam longint unsigned RECIP =
        ((64'd1 << S_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);

    // bitmap storage
    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;

    // control registers
    state_t               state_reg,   state_next;
    logic [AW-1:0]        clr_ptr_reg, clr_ptr_next;
    logic [AW-1:0]        lcw_reg,     lcw_next;
    logic [CW-1:0]        cnt_reg,     cnt_next;
    logic [VALUE_W-1:0]   base_reg,    base_next;
    logic                 done_reg,    done_next;

    // datapath registers
    logic [OFF_W-1:0]     dq_reg,        dq_next;
    logic [RW-1:0]        rem_reg,       rem_next;
    logic [AW-1:0]        quo_reg,       quo_next;
    logic [AW-1:0]        scan_ptr_reg,  scan_ptr_next;
    logic [AW-1:0]        data_addr_reg, data_addr_next;
    logic [BW-1:0]        hit_idx_reg,   hit_idx_next;
    logic [WORD_BITS-1:0] clr_word_reg,  clr_word_next;
    logic                 found_reg,     found_next;
    logic [VALUE_W-1:0]   value_reg,     value_next;

    // combinational helpers
    logic [VALUE_W:0]     off_full;
    logic                 in_win;
    logic [OFF_W-1:0]     off;
    logic [PW-1:0]        quo_prod;
    logic [OFF_W-1:0]     rem_full;
    logic [AW-1:0]        ins_word;
    logic [BW-1:0]        ins_bit;
    logic [WORD_BITS-1:0] ins_mask;
    logic [IDX_W-1:0]     pop_idx;
    logic [IDX_W-1:0]     pop_sum;
    lowbit_t              low;
    logic [WORD_BITS-1:0] low_cleared;

    wbs_lowbit
    #(
        .WORD_BITS (WORD_BITS)
    )
    u_lowbit
    (
        .word    (rd_data_reg),
        .low     (low),
        .cleared (low_cleared)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done         = done_reg;
    assign found        = found_reg;
    assign sorted_value = value_reg;

    assign off_full = {1'b0, value} - {1'b0, base_reg};
    assign in_win   = !off_full[VALUE_W] && (off_full < IDX_W'(WINDOW));
    assign off      = off_full[OFF_W-1:0];

    // word index by reciprocal multiply, bit index from the product back
    assign quo_prod = PW'(dq_reg) * PW'(RECIP);
    assign rem_full = dq_reg - OFF_W'(quo_reg) * OFF_W'(WORD_BITS);

    assign ins_word = dq_reg[AW-1:0];
    assign ins_bit  = rem_reg[BW-1:0];
    assign ins_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << ins_bit;

    assign pop_idx = IDX_W'(data_addr_reg) * IDX_W'(WORD_BITS) + IDX_W'(hit_idx_reg);
    assign pop_sum = {1'b0, base_reg} + pop_idx;

    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        lcw_next       = lcw_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        done_next      = 1'b0;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        scan_ptr_next  = scan_ptr_reg;
        data_addr_next = data_addr_reg;
        hit_idx_next   = hit_idx_reg;
        clr_word_next  = clr_word_reg;
        found_next     = found_reg;
        value_next     = value_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = lcw_reg;
        mem_we         = 1'b0;
        mem_wr_addr    = clr_ptr_reg;
        mem_wr_data    = '0;

        if (cfg_valid && cfg_ready)
        begin
            base_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wr_addr  = clr_ptr_reg;
                mem_wr_data  = '0;
                clr_ptr_next = clr_ptr_reg + AW'(1);
                if (clr_ptr_reg == AW'(NWORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_INSERT)
                    begin
                        if (!in_win)
                        begin
                            done_next  = 1'b1;
                            found_next = 1'b0;
                            value_next = '0;
                        end
                        else if (WB_POW2)
                        begin
                            dq_next    = off >> BW;
                            rem_next   = RW'(off & OFF_W'(WORD_BITS - 1));
                            state_next = ST_INS_RD;
                        end
                        else
                        begin
                            dq_next    = off;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            done_next  = 1'b1;
                            found_next = 1'b0;
                            value_next = '0;
                        end
                        else
                        begin
                            mem_rd_en      = 1'b1;
                            mem_rd_addr    = lcw_reg;
                            data_addr_next = lcw_reg;
                            scan_ptr_next  = lcw_reg + AW'(1);
                            state_next     = ST_POP_SCAN;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                quo_next   = quo_prod[S_SH +: AW];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                rem_next   = RW'(rem_full);
                dq_next    = OFF_W'(quo_reg);
                state_next = ST_INS_RD;
            end
            ST_INS_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ins_word;
                state_next  = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = ins_word;
                mem_wr_data = rd_data_reg | ins_mask;
                if ((rd_data_reg & ins_mask) == '0)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (ins_word < lcw_reg)
                begin
                    lcw_next = ins_word;
                end
                done_next  = 1'b1;
                found_next = 1'b1;
                value_next = '0;
                state_next = ST_IDLE;
            end
            ST_POP_SCAN:
            begin
                // a set bit at or above the candidate word always exists here
                if (low.hit)
                begin
                    hit_idx_next  = low.idx[BW-1:0];
                    clr_word_next = low_cleared;
                    state_next    = ST_POP_WR;
                end
                else
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = scan_ptr_reg;
                    data_addr_next = scan_ptr_reg;
                    scan_ptr_next  = scan_ptr_reg + AW'(1);
                end
            end
            ST_POP_WR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = data_addr_reg;
                mem_wr_data = clr_word_reg;
                lcw_next    = data_addr_reg;
                cnt_next    = cnt_reg - CW'(1);
                done_next   = 1'b1;
                found_next  = 1'b1;
                value_next  = pop_sum[VALUE_W-1:0];
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            lcw_reg     <= '0;
            cnt_reg     <= '0;
            base_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            lcw_reg     <= lcw_next;
            cnt_reg     <= cnt_next;
            base_reg    <= base_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        scan_ptr_reg  <= scan_ptr_next;
        data_addr_reg <= data_addr_next;
        hit_idx_reg   <= hit_idx_next;
        clr_word_reg  <= clr_word_next;
        found_reg     <= found_next;
        value_reg     <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

endmodule

[hdl/wbs_checker.sv]
// ----------------------------------------------------------------------------
// wbs_checker
// port-level checks of the request and result channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "windowed_bitmap_sorter_macros.svh"

module wbs_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        done,
    input  logic                        found,
    input  logic [wbs_pkg::VALUE_W-1:0] sorted_value
);
    import wbs_pkg::*;

    // every accepted request either occupies the block or answers at once
    `WBS_ASSERT_NEXT(a_req_answered, start && !busy, busy || done, "request neither busy nor done")

    // a result only shows once the block has gone idle
    `WBS_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

    // one request gives one result pulse
    `WBS_ASSERT_NEXT(a_single_pulse, done && !(start && !busy), !done, "result repeated")

    // a miss carries a zero value (a plain insert does too, but is not checked here)
    `WBS_ASSERT_SAME(a_miss_zero, done && !found, sorted_value == '0, "miss with nonzero value")

endmodule

bind windowed_bitmap_sorter wbs_checker u_wbs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .found        (found),
    .sorted_value (sorted_value)
);
